@@ rtl/core/pidfd_pkg.sv @@
`timescale 1ns / 1ps

package pidfd_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned SUM_W     = 35;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned STEP_W    = 4;

  localparam bit SERIAL_FORM = 1'b0;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd32768;
  localparam logic signed [PROD_W-1:0] SAT_MAX    = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN    = -64'sd2147483648;

  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_COEF    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_COEF    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_POLE_COEF     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_FLOOR   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_CEILING = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd7;

  localparam logic signed [DATA_W-1:0] PROP_GAIN_RESET = 32'sd65536;
  localparam logic signed [DATA_W-1:0] Q_MAX           = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] Q_MIN           = 32'sh80000000;

  localparam logic [1:0] COND_NONE = 2'd0;
  localparam logic [1:0] COND_IN   = 2'd1;
  localparam logic [1:0] COND_OUT  = 2'd2;

  localparam logic [3:0] SRC_ZERO   = 4'd0;
  localparam logic [3:0] SRC_TARGET = 4'd1;
  localparam logic [3:0] SRC_MEAS   = 4'd2;
  localparam logic [3:0] SRC_LMEAS  = 4'd3;
  localparam logic [3:0] SRC_ERR    = 4'd4;
  localparam logic [3:0] SRC_LERR   = 4'd5;
  localparam logic [3:0] SRC_INTEG  = 4'd6;
  localparam logic [3:0] SRC_DERIV  = 4'd7;
  localparam logic [3:0] SRC_Q      = 4'd8;
  localparam logic [3:0] SRC_T      = 4'd9;
  localparam logic [3:0] SRC_D      = 4'd10;

  localparam logic [2:0] DST_NONE  = 3'd0;
  localparam logic [2:0] DST_ERR   = 3'd1;
  localparam logic [2:0] DST_T     = 3'd2;
  localparam logic [2:0] DST_D     = 3'd3;
  localparam logic [2:0] DST_INTEG = 3'd4;
  localparam logic [2:0] DST_DERIV = 3'd5;
  localparam logic [2:0] DST_DRIVE = 3'd6;

  localparam logic [1:0] MA_PROP  = 2'd0;
  localparam logic [1:0] MA_ICOEF = 2'd1;
  localparam logic [1:0] MA_DCOEF = 2'd2;
  localparam logic [1:0] MA_PCOEF = 2'd3;

  localparam logic [1:0] MB_T     = 2'd0;
  localparam logic [1:0] MB_D     = 2'd1;
  localparam logic [1:0] MB_DERIV = 2'd2;
  localparam logic [1:0] MB_ERR   = 2'd3;

  typedef struct packed {
    logic [1:0]        cond;
    logic              jump;
    logic [STEP_W-1:0] jump_addr;
    logic [3:0]        a_sel;
    logic [3:0]        b_sel;
    logic              b_neg;
    logic [3:0]        c_sel;
    logic [2:0]        dst;
    logic              mul_en;
    logic [1:0]        ma_sel;
    logic [1:0]        mb_sel;
  } ctrl_word_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) r = Q_MAX;
    else if (v < SAT_MIN) r = Q_MIN;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [DATA_W-1:0] v,
                                                       input logic signed [DATA_W-1:0] lo,
                                                       input logic signed [DATA_W-1:0] hi);
    logic signed [DATA_W-1:0] r;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    else r = v;
    return r;
  endfunction

  function automatic ctrl_word_t alu_op(input logic [3:0] a, input logic [3:0] b,
                                        input logic neg, input logic [3:0] c,
                                        input logic [2:0] dst);
    ctrl_word_t cw;
    cw = '0;
    cw.a_sel = a;
    cw.b_sel = b;
    cw.b_neg = neg;
    cw.c_sel = c;
    cw.dst   = dst;
    return cw;
  endfunction

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '0;
    case (step)
      4'd0: cw.cond = COND_IN;
      4'd1: cw = alu_op(SRC_TARGET, SRC_MEAS, 1'b1, SRC_ZERO, DST_ERR);
      4'd2: cw = alu_op(SRC_ERR, SRC_LERR, 1'b0, SRC_ZERO, DST_T);
      4'd3: begin
        cw = alu_op(SRC_MEAS, SRC_LMEAS, 1'b1, SRC_ZERO, DST_D);
        cw.mul_en = 1'b1;
        cw.ma_sel = MA_ICOEF;
        cw.mb_sel = MB_T;
      end
      4'd4: begin
        cw = alu_op(SRC_INTEG, SRC_Q, 1'b0, SRC_ZERO, DST_INTEG);
        cw.mul_en = 1'b1;
        cw.ma_sel = MA_DCOEF;
        cw.mb_sel = MB_D;
      end
      4'd5: begin
        cw = alu_op(SRC_Q, SRC_ZERO, 1'b0, SRC_ZERO, DST_T);
        cw.mul_en = 1'b1;
        cw.ma_sel = MA_PCOEF;
        cw.mb_sel = MB_DERIV;
      end
      4'd6: begin
        cw = alu_op(SRC_Q, SRC_T, 1'b1, SRC_ZERO, DST_DERIV);
        if (!SERIAL_FORM) begin
          cw.mul_en = 1'b1;
          cw.ma_sel = MA_PROP;
          cw.mb_sel = MB_ERR;
        end
      end
      4'd7: begin
        if (SERIAL_FORM) begin
          cw = alu_op(SRC_ERR, SRC_INTEG, 1'b0, SRC_DERIV, DST_T);
        end else begin
          cw = alu_op(SRC_Q, SRC_INTEG, 1'b0, SRC_DERIV, DST_DRIVE);
          cw.cond      = COND_OUT;
          cw.jump      = 1'b1;
          cw.jump_addr = 4'd0;
        end
      end
      4'd8: begin
        cw.mul_en = 1'b1;
        cw.ma_sel = MA_PROP;
        cw.mb_sel = MB_T;
      end
      4'd9: begin
        cw = alu_op(SRC_Q, SRC_ZERO, 1'b0, SRC_ZERO, DST_DRIVE);
        cw.cond      = COND_OUT;
        cw.jump      = 1'b1;
        cw.jump_addr = 4'd0;
      end
      default: begin
        cw.jump      = 1'b1;
        cw.jump_addr = 4'd0;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/core/pidfd_if.sv @@
`timescale 1ns / 1ps

interface pidfd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pidfd_pkg::DATA_W-1:0]  target;
  logic signed [pidfd_pkg::DATA_W-1:0]  measured;
  modport source(output valid, output target, output measured, input ready);
  modport sink(input valid, input target, input measured, output ready);
endinterface

interface pidfd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pidfd_pkg::DATA_W-1:0]  drive;
  modport source(output valid, output drive, input ready);
  modport sink(input valid, input drive, output ready);
endinterface

interface pidfd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [pidfd_pkg::REG_IDX_W-1:0]      index;
  logic [pidfd_pkg::DATA_W-1:0]         data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/core/pid_controller_filtered_derivative.sv @@
`timescale 1ns / 1ps

// PID controller, Q16.16, trapezoidal integral and band-limited derivative.
// in_ch carries target and measured; out_ch carries one clamped drive per
// input transfer; cfg_ch writes the eight coefficient and limit registers
// (index 0..7) and is always ready; write it only while the block is idle.
// A microcode table steps one adder/saturator and one 32x32 multiplier
// with a registered product. The table runs 7 compute steps (parallel form)
// or 9 (serial form) after the input transfer; the last step loads the
// drive and returns to the input step, so a new input is taken only after
// the result is loaded. The steps follow the chain of dependent
// multiplies through the one multiplier.
// The output register parts the two sides: the next item is taken and
// computed while a result waits; if the receiver still stalls when the next
// drive is ready, the last step holds until the output register frees.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// integrator, derivative and history state, and empties the output.
module pid_controller_filtered_derivative (
  input  logic             clk,
  input  logic             rst_n,
  pidfd_in_if.sink         in_ch,
  pidfd_out_if.source      out_ch,
  pidfd_cfg_if.sink        cfg_ch
);

  logic signed [pidfd_pkg::DATA_W-1:0] coef_r [8];

  logic [pidfd_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic signed [pidfd_pkg::DATA_W-1:0] target_r, meas_r;
  logic signed [pidfd_pkg::DATA_W-1:0] err_r, t_r, d_r, drive_r;
  logic signed [pidfd_pkg::DATA_W-1:0] integ_r, deriv_r, last_err_r, last_meas_r;
  logic signed [pidfd_pkg::PROD_W-1:0] prod_r;

  pidfd_pkg::ctrl_word_t cw;
  logic go;

  logic signed [pidfd_pkg::DATA_W-1:0] q_val;
  logic signed [pidfd_pkg::PROD_W-1:0] prod_rnd;
  logic signed [pidfd_pkg::DATA_W-1:0] src_a, src_b, src_c, mul_a, mul_b;
  logic signed [pidfd_pkg::SUM_W-1:0]  sum_b, sum_all;
  logic signed [pidfd_pkg::DATA_W-1:0] alu_res;

  assign cw = pidfd_pkg::ucode(step_r);

  assign in_ch.ready  = (cw.cond == pidfd_pkg::COND_IN);
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = drive_r;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    case (cw.cond)
      pidfd_pkg::COND_IN:  go = in_ch.valid;
      pidfd_pkg::COND_OUT: go = !out_valid_r || out_ch.ready;
      default:             go = 1'b1;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (go) step_nxt = cw.jump ? cw.jump_addr : step_r + 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (go && cw.dst == pidfd_pkg::DST_DRIVE) out_valid_nxt = 1'b1;
  end

  assign prod_rnd = prod_r + pidfd_pkg::ROUND_HALF;
  assign q_val    = pidfd_pkg::sat32(prod_rnd >>> pidfd_pkg::FRAC_BITS);

  always_comb begin
    case (cw.a_sel)
      pidfd_pkg::SRC_TARGET: src_a = target_r;
      pidfd_pkg::SRC_MEAS:   src_a = meas_r;
      pidfd_pkg::SRC_LMEAS:  src_a = last_meas_r;
      pidfd_pkg::SRC_ERR:    src_a = err_r;
      pidfd_pkg::SRC_LERR:   src_a = last_err_r;
      pidfd_pkg::SRC_INTEG:  src_a = integ_r;
      pidfd_pkg::SRC_DERIV:  src_a = deriv_r;
      pidfd_pkg::SRC_Q:      src_a = q_val;
      pidfd_pkg::SRC_T:      src_a = t_r;
      pidfd_pkg::SRC_D:      src_a = d_r;
      default:               src_a = '0;
    endcase
    case (cw.b_sel)
      pidfd_pkg::SRC_TARGET: src_b = target_r;
      pidfd_pkg::SRC_MEAS:   src_b = meas_r;
      pidfd_pkg::SRC_LMEAS:  src_b = last_meas_r;
      pidfd_pkg::SRC_ERR:    src_b = err_r;
      pidfd_pkg::SRC_LERR:   src_b = last_err_r;
      pidfd_pkg::SRC_INTEG:  src_b = integ_r;
      pidfd_pkg::SRC_DERIV:  src_b = deriv_r;
      pidfd_pkg::SRC_Q:      src_b = q_val;
      pidfd_pkg::SRC_T:      src_b = t_r;
      pidfd_pkg::SRC_D:      src_b = d_r;
      default:               src_b = '0;
    endcase
    case (cw.c_sel)
      pidfd_pkg::SRC_TARGET: src_c = target_r;
      pidfd_pkg::SRC_MEAS:   src_c = meas_r;
      pidfd_pkg::SRC_LMEAS:  src_c = last_meas_r;
      pidfd_pkg::SRC_ERR:    src_c = err_r;
      pidfd_pkg::SRC_LERR:   src_c = last_err_r;
      pidfd_pkg::SRC_INTEG:  src_c = integ_r;
      pidfd_pkg::SRC_DERIV:  src_c = deriv_r;
      pidfd_pkg::SRC_Q:      src_c = q_val;
      pidfd_pkg::SRC_T:      src_c = t_r;
      pidfd_pkg::SRC_D:      src_c = d_r;
      default:               src_c = '0;
    endcase
  end

  always_comb begin
    sum_b   = cw.b_neg ? -pidfd_pkg::SUM_W'(src_b) : pidfd_pkg::SUM_W'(src_b);
    sum_all = pidfd_pkg::SUM_W'(src_a) + sum_b + pidfd_pkg::SUM_W'(src_c);
    alu_res = pidfd_pkg::sat32(pidfd_pkg::PROD_W'(sum_all));
  end

  always_comb begin
    case (cw.ma_sel)
      pidfd_pkg::MA_ICOEF: mul_a = coef_r[pidfd_pkg::REG_INTEG_COEF];
      pidfd_pkg::MA_DCOEF: mul_a = coef_r[pidfd_pkg::REG_DERIV_COEF];
      pidfd_pkg::MA_PCOEF: mul_a = coef_r[pidfd_pkg::REG_POLE_COEF];
      default:             mul_a = coef_r[pidfd_pkg::REG_PROP_GAIN];
    endcase
    case (cw.mb_sel)
      pidfd_pkg::MB_D:     mul_b = d_r;
      pidfd_pkg::MB_DERIV: mul_b = deriv_r;
      pidfd_pkg::MB_ERR:   mul_b = err_r;
      default:             mul_b = t_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      deriv_r     <= '0;
      last_err_r  <= '0;
      last_meas_r <= '0;
      coef_r[pidfd_pkg::REG_PROP_GAIN]     <= pidfd_pkg::PROP_GAIN_RESET;
      coef_r[pidfd_pkg::REG_INTEG_COEF]    <= '0;
      coef_r[pidfd_pkg::REG_DERIV_COEF]    <= '0;
      coef_r[pidfd_pkg::REG_POLE_COEF]     <= '0;
      coef_r[pidfd_pkg::REG_INTEG_FLOOR]   <= pidfd_pkg::Q_MIN;
      coef_r[pidfd_pkg::REG_INTEG_CEILING] <= pidfd_pkg::Q_MAX;
      coef_r[pidfd_pkg::REG_DRIVE_FLOOR]   <= pidfd_pkg::Q_MIN;
      coef_r[pidfd_pkg::REG_DRIVE_CEILING] <= pidfd_pkg::Q_MAX;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) coef_r[cfg_ch.index] <= cfg_ch.data;
      if (go && cw.dst == pidfd_pkg::DST_INTEG)
        integ_r <= pidfd_pkg::clamp32(alu_res, coef_r[pidfd_pkg::REG_INTEG_FLOOR],
                                      coef_r[pidfd_pkg::REG_INTEG_CEILING]);
      if (go && cw.dst == pidfd_pkg::DST_DERIV) deriv_r <= alu_res;
      if (go && cw.dst == pidfd_pkg::DST_DRIVE) begin
        last_err_r  <= err_r;
        last_meas_r <= meas_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      target_r <= in_ch.target;
      meas_r   <= in_ch.measured;
    end
    if (go && cw.mul_en) prod_r <= mul_a * mul_b;
    if (go) begin
      case (cw.dst)
        pidfd_pkg::DST_ERR: err_r <= alu_res;
        pidfd_pkg::DST_T:   t_r   <= alu_res;
        pidfd_pkg::DST_D:   d_r   <= alu_res;
        pidfd_pkg::DST_DRIVE:
          drive_r <= pidfd_pkg::clamp32(alu_res, coef_r[pidfd_pkg::REG_DRIVE_FLOOR],
                                        coef_r[pidfd_pkg::REG_DRIVE_CEILING]);
        default: ;
      endcase
    end
  end

endmodule

@@ test/tb_pid_controller_filtered_derivative.sv @@
`timescale 1ns / 1ps

module tb_pid_controller_filtered_derivative;

  typedef logic signed [pidfd_pkg::DATA_W-1:0] q16_t;

  typedef struct packed {
    q16_t target;
    q16_t measured;
  } sample_t;

  localparam longint QHI         = 64'sd2147483647;
  localparam longint QLO         = -64'sd2147483648;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     RAND_PHASES = 6;
  localparam int     PHASE_ITEMS = 72;
  localparam int     HOLD_AT     = 120;
  localparam int     HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n;

  pidfd_in_if  in_ch();
  pidfd_out_if out_ch();
  pidfd_cfg_if cfg_ch();

  pid_controller_filtered_derivative uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  sample_t samples_pending[$];
  q16_t    drive_due[$];
  q16_t    coef [8];
  q16_t    plan [8];
  q16_t    acc_integ, err_prev, acc_deriv, meas_prev;
  int      mismatches = 0;
  int      samples_taken = 0;
  int      cycles = 0;
  logic    in_sent = 1'b0;
  logic    hold_off = 1'b0;
  int      burst_left = 0;
  int      gap_left = 0;
  int      rx_mode = 0;
  int      rx_left = 0;
  int      rx_tick = 0;

  function automatic q16_t sat_q(input longint v);
    if (v > QHI) return pidfd_pkg::Q_MAX;
    if (v < QLO) return pidfd_pkg::Q_MIN;
    return q16_t'(v);
  endfunction

  function automatic q16_t mul_q(input q16_t a, input q16_t b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return sat_q(p >>> pidfd_pkg::FRAC_BITS);
  endfunction

  function automatic q16_t limit_q(input q16_t v, input q16_t lo, input q16_t hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic q16_t predict_drive(input q16_t target, input q16_t measured);
    q16_t err, esum, dm, drive;
    err = sat_q(longint'(target) - longint'(measured));
    esum = sat_q(longint'(err) + longint'(err_prev));
    acc_integ = sat_q(longint'(acc_integ)
                      + longint'(mul_q(coef[pidfd_pkg::REG_INTEG_COEF], esum)));
    acc_integ = limit_q(acc_integ, coef[pidfd_pkg::REG_INTEG_FLOOR],
                        coef[pidfd_pkg::REG_INTEG_CEILING]);
    dm = sat_q(longint'(measured) - longint'(meas_prev));
    acc_deriv = sat_q(longint'(mul_q(coef[pidfd_pkg::REG_POLE_COEF], acc_deriv))
                      - longint'(mul_q(coef[pidfd_pkg::REG_DERIV_COEF], dm)));
    if (pidfd_pkg::SERIAL_FORM) begin
      drive = mul_q(coef[pidfd_pkg::REG_PROP_GAIN],
                    sat_q(longint'(err) + longint'(acc_integ) + longint'(acc_deriv)));
    end else begin
      drive = sat_q(longint'(mul_q(coef[pidfd_pkg::REG_PROP_GAIN], err))
                    + longint'(acc_integ) + longint'(acc_deriv));
    end
    err_prev = err;
    meas_prev = measured;
    return limit_q(drive, coef[pidfd_pkg::REG_DRIVE_FLOOR],
                   coef[pidfd_pkg::REG_DRIVE_CEILING]);
  endfunction

  function automatic q16_t pick_gain();
    case ($urandom_range(0, 9))
      0: return pidfd_pkg::Q_MAX;
      1: return pidfd_pkg::Q_MIN;
      2: return '0;
      3: return q16_t'($urandom);
      default: return q16_t'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic q16_t wild_value();
    case ($urandom_range(0, 5))
      0: return pidfd_pkg::Q_MAX;
      1: return pidfd_pkg::Q_MIN;
      2, 3: return q16_t'($urandom);
      default: return q16_t'(int'($urandom_range(0, 33554432)) - 16777216);
    endcase
  endfunction

  task automatic pick_bounds(output q16_t lo, output q16_t hi);
    q16_t a, b;
    a = q16_t'(int'($urandom_range(0, 33554432)) - 16777216);
    b = q16_t'(int'($urandom_range(0, 33554432)) - 16777216);
    case ($urandom_range(0, 3))
      0: begin
        lo = pidfd_pkg::Q_MIN;
        hi = pidfd_pkg::Q_MAX;
      end
      1: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      2: begin
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end
      default: begin
        lo = pidfd_pkg::Q_MIN;
        hi = a;
      end
    endcase
  endtask

  task automatic report(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic queue_sample(input q16_t t, input q16_t m);
    sample_t s;
    s.target = t;
    s.measured = m;
    samples_pending.push_back(s);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= pidfd_pkg::REG_IDX_W'(i);
      cfg_ch.data  <= plan[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (samples_pending.size() != 0 || in_ch.valid || drive_due.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  // input driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    sample_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_sent) begin
      // hold until the transfer happens
    end else if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      gap_left--;
    end else if (samples_pending.size() != 0) begin
      nxt = samples_pending.pop_front();
      in_ch.valid    <= 1'b1;
      in_ch.target   <= nxt.target;
      in_ch.measured <= nxt.measured;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        if ($urandom_range(0, 2) == 0) gap_left = 0;
        else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(10, 40);
        else gap_left = $urandom_range(1, 5);
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result receiver: switches among four stall patterns, chosen at random
  always @(negedge clk) begin
    logic r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 96);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        0: r = 1'b1;
        1: r = $urandom_range(0, 1) != 0;
        2: r = $urandom_range(0, 3) == 0;
        default: r = (rx_tick % 5) < 2;
      endcase
      out_ch.ready <= r && !hold_off;
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (samples_taken >= HOLD_AT);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    q16_t want;
    in_sent = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) coef[cfg_ch.index] = cfg_ch.data;
      if (out_ch.valid && out_ch.ready) begin
        if (drive_due.size() == 0) begin
          report($sformatf("drive %h with no transfer pending", out_ch.drive));
        end else begin
          want = drive_due.pop_front();
          if (out_ch.drive !== want)
            report($sformatf("drive %h, predicted %h", out_ch.drive, want));
        end
      end
      if (in_sent) begin
        drive_due.push_back(predict_drive(in_ch.target, in_ch.measured));
        samples_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    q16_t setp, plant;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.target = '0;
    in_ch.measured = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    coef[pidfd_pkg::REG_PROP_GAIN] = pidfd_pkg::PROP_GAIN_RESET;
    coef[pidfd_pkg::REG_INTEG_COEF] = '0;
    coef[pidfd_pkg::REG_DERIV_COEF] = '0;
    coef[pidfd_pkg::REG_POLE_COEF] = '0;
    coef[pidfd_pkg::REG_INTEG_FLOOR] = pidfd_pkg::Q_MIN;
    coef[pidfd_pkg::REG_INTEG_CEILING] = pidfd_pkg::Q_MAX;
    coef[pidfd_pkg::REG_DRIVE_FLOOR] = pidfd_pkg::Q_MIN;
    coef[pidfd_pkg::REG_DRIVE_CEILING] = pidfd_pkg::Q_MAX;
    acc_integ = '0;
    err_prev = '0;
    acc_deriv = '0;
    meas_prev = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes, saturated error and measurement step, open limits
    plan[pidfd_pkg::REG_PROP_GAIN] = 32'sh0001_0000;
    plan[pidfd_pkg::REG_INTEG_COEF] = 32'sh0000_4000;
    plan[pidfd_pkg::REG_DERIV_COEF] = 32'sh0000_8000;
    plan[pidfd_pkg::REG_POLE_COEF] = 32'sh0000_8000;
    plan[pidfd_pkg::REG_INTEG_FLOOR] = pidfd_pkg::Q_MIN;
    plan[pidfd_pkg::REG_INTEG_CEILING] = pidfd_pkg::Q_MAX;
    plan[pidfd_pkg::REG_DRIVE_FLOOR] = pidfd_pkg::Q_MIN;
    plan[pidfd_pkg::REG_DRIVE_CEILING] = pidfd_pkg::Q_MAX;
    write_regs();
    queue_sample('0, '0);
    queue_sample(pidfd_pkg::Q_MAX, pidfd_pkg::Q_MIN);
    queue_sample(pidfd_pkg::Q_MIN, pidfd_pkg::Q_MAX);
    queue_sample(pidfd_pkg::Q_MAX, pidfd_pkg::Q_MAX);
    queue_sample(pidfd_pkg::Q_MIN, pidfd_pkg::Q_MIN);
    queue_sample('0, pidfd_pkg::Q_MIN);
    queue_sample('0, pidfd_pkg::Q_MAX);
    queue_sample(32'sd1, -32'sd1);
    queue_sample(-32'sd1, 32'sd1);
    drain();

    // extreme coefficients: saturated products and a runaway pole
    plan[pidfd_pkg::REG_PROP_GAIN] = pidfd_pkg::Q_MAX;
    plan[pidfd_pkg::REG_INTEG_COEF] = pidfd_pkg::Q_MAX;
    plan[pidfd_pkg::REG_DERIV_COEF] = pidfd_pkg::Q_MIN;
    plan[pidfd_pkg::REG_POLE_COEF] = pidfd_pkg::Q_MAX;
    write_regs();
    queue_sample(pidfd_pkg::Q_MAX, '0);
    queue_sample('0, pidfd_pkg::Q_MAX);
    queue_sample(pidfd_pkg::Q_MIN, '0);
    queue_sample(32'sh0001_0000, -32'sh0001_0000);
    queue_sample('0, '0);
    queue_sample(32'sh0000_8000, '0);
    drain();

    // crossed integrator and output limits, negative gains
    plan[pidfd_pkg::REG_PROP_GAIN] = pidfd_pkg::Q_MIN;
    plan[pidfd_pkg::REG_INTEG_COEF] = 32'sh0001_0000;
    plan[pidfd_pkg::REG_DERIV_COEF] = 32'sh0001_0000;
    plan[pidfd_pkg::REG_POLE_COEF] = pidfd_pkg::Q_MIN;
    plan[pidfd_pkg::REG_INTEG_FLOOR] = 32'sh0001_0000;
    plan[pidfd_pkg::REG_INTEG_CEILING] = -32'sh0001_0000;
    plan[pidfd_pkg::REG_DRIVE_FLOOR] = 32'sh0005_0000;
    plan[pidfd_pkg::REG_DRIVE_CEILING] = -32'sh0005_0000;
    write_regs();
    queue_sample(32'sh0010_0000, '0);
    queue_sample(-32'sh0010_0000, '0);
    queue_sample('0, 32'sh0020_0000);
    queue_sample('0, '0);
    queue_sample(32'sh0000_8000, 32'sh0000_7fff);
    queue_sample(pidfd_pkg::Q_MIN, pidfd_pkg::Q_MAX);
    drain();

    setp = 32'sh0010_0000;
    plant = '0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      plan[pidfd_pkg::REG_PROP_GAIN] = pick_gain();
      plan[pidfd_pkg::REG_INTEG_COEF] = pick_gain();
      plan[pidfd_pkg::REG_DERIV_COEF] = pick_gain();
      plan[pidfd_pkg::REG_POLE_COEF] = ($urandom_range(0, 3) == 0) ? pick_gain()
                                     : q16_t'(int'($urandom_range(0, 81920)) - 16384);
      pick_bounds(plan[pidfd_pkg::REG_INTEG_FLOOR], plan[pidfd_pkg::REG_INTEG_CEILING]);
      pick_bounds(plan[pidfd_pkg::REG_DRIVE_FLOOR], plan[pidfd_pkg::REG_DRIVE_CEILING]);
      write_regs();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 15) == 0) setp = wild_value();
        plant = sat_q(longint'(plant) + ((longint'(setp) - longint'(plant)) >>> 3)
                      + longint'(int'($urandom_range(0, 4096)) - 2048));
        if ($urandom_range(0, 9) == 0) queue_sample(wild_value(), wild_value());
        else queue_sample(setp, plant);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
